// ===== design/cas_pkg.sv =====
// shared types and constants for the click and alarm tone synth
// no dependencies; imported by the interfaces, the divider, the phase counter and the top level
package cas_pkg;

  localparam int FUNC_W      = 2;
  localparam int SAMPLE_W    = 16;
  localparam int LEN_W       = 16;
  localparam int HALF_W      = 8;
  localparam int AMP_W       = 15;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // envelope divide: amplitude * remaining over click length
  localparam int DIVIDEND_W  = AMP_W + LEN_W;
  localparam int DIVISOR_W   = LEN_W;
  localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);
  localparam int MIX_W       = DIVIDEND_W + 2;

  typedef logic [FUNC_W-1:0] func_t;

  localparam func_t FUNC_TICK  = 2'd0;
  localparam func_t FUNC_CLICK = 2'd1;
  localparam func_t FUNC_ALARM = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_CLICK_LENGTH      = 3'd0;
  localparam cfg_idx_t CFG_CLICK_HALF_PERIOD = 3'd1;
  localparam cfg_idx_t CFG_ALARM_HALF_PERIOD = 3'd2;
  localparam cfg_idx_t CFG_CLICK_AMPLITUDE   = 3'd3;
  localparam cfg_idx_t CFG_ALARM_AMPLITUDE   = 3'd4;

  localparam logic [LEN_W-1:0]  RST_CLICK_LENGTH      = 16'd551;
  localparam logic [HALF_W-1:0] RST_CLICK_HALF_PERIOD = 8'd5;
  localparam logic [HALF_W-1:0] RST_ALARM_HALF_PERIOD = 8'd12;
  localparam logic [AMP_W-1:0]  RST_CLICK_AMPLITUDE   = 15'd9000;
  localparam logic [AMP_W-1:0]  RST_ALARM_AMPLITUDE   = 15'd6000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULT,
    ST_DIV,
    ST_MIX
  } cas_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== design/cas_if.sv =====
// valid/ready channel interfaces for command items and output samples
// depends on cas_pkg
interface cas_in_if;
  import cas_pkg::*;
  logic  valid;
  logic  ready;
  func_t func;
  logic  alarm_level;

  modport source (output valid, output func, output alarm_level, input ready);
  modport sink   (input valid, input func, input alarm_level, output ready);
endinterface

interface cas_out_if;
  import cas_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== design/cas_divider.sv =====
// restoring divider, one quotient bit per cycle, for the click envelope
// depends on cas_pkg
module cas_divider (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [cas_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [cas_pkg::DIVISOR_W-1:0]    divisor,
  output cas_pkg::div_status_t             status,
  output logic [cas_pkg::DIVIDEND_W-1:0]   quotient
);
  import cas_pkg::*;

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0]  quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]   div_r, div_nxt;
  logic [DIVISOR_W:0]     rem_r, rem_nxt;
  logic [DIVISOR_W:0]     rem_sh;
  logic [DIVISOR_W:0]     rem_sub;
  logic                   fits;

  assign rem_sh  = {rem_r[DIVISOR_W-1:0], quo_r[DIVIDEND_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign fits    = rem_sh >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // shift the next dividend bit in, quotient bits fill from the bottom
      rem_nxt = fits ? rem_sub : rem_sh;
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

endmodule

// ===== design/cas_phase.sv =====
// half-period step counter and polarity bit of one square-wave voice
// depends on cas_pkg
module cas_phase (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        clear,
  input  logic [cas_pkg::HALF_W-1:0]  half_period,
  output logic                        polarity
);
  import cas_pkg::*;

  logic [HALF_W-1:0] count_r, count_nxt;
  logic              pol_r, pol_nxt;
  logic [HALF_W-1:0] half_eff;
  logic [HALF_W:0]   count_inc;

  // a zero half period behaves as one
  assign half_eff  = (half_period == '0) ? HALF_W'(1) : half_period;
  assign count_inc = {1'b0, count_r} + 1'b1;

  always_comb begin
    count_nxt = count_r;
    pol_nxt   = pol_r;
    if (clear) begin
      count_nxt = '0;
      pol_nxt   = 1'b0;
    end else if (step) begin
      if (count_inc >= {1'b0, half_eff}) begin
        count_nxt = '0;
        pol_nxt   = ~pol_r;
      end else begin
        count_nxt = count_inc[HALF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pol_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pol_r   <= pol_nxt;
    end
  end

  assign polarity = pol_r;

endmodule

// ===== design/click_and_alarm_tone_synth.sv =====
// two-voice square-wave synth: decaying click burst plus switchable alarm tone
// click and level transactions give no sample
// a tick with a running click and nonzero length goes through ST_MULT, the 31-step divider
// and ST_MIX; any other tick goes straight to ST_MIX, which registers the sample
// one transaction at a time; in.ready is high only while the sequencer is idle
// synchronous reset restores the default registers, clears all voice state and the output valid flag
module click_and_alarm_tone_synth (
  input  logic                          clk,
  input  logic                          rst_n,
  cas_in_if.sink                        in_chan,
  cas_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [cas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cas_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cas_pkg::*;

  // configuration registers
  logic [LEN_W-1:0]  click_length_r;
  logic [HALF_W-1:0] click_half_r;
  logic [HALF_W-1:0] alarm_half_r;
  logic [AMP_W-1:0]  click_amp_r;
  logic [AMP_W-1:0]  alarm_amp_r;

  // voice state
  logic              alarm_en_r, alarm_en_nxt;
  logic [LEN_W-1:0]  click_left_r, click_left_nxt;

  // per-tick snapshot
  cas_state_t        state_r, state_nxt;
  logic [LEN_W-1:0]  left_snap_r, left_snap_nxt;
  logic              cpol_snap_r, cpol_snap_nxt;
  logic              apol_snap_r, apol_snap_nxt;
  logic              alarm_snap_r, alarm_snap_nxt;
  logic [DIVIDEND_W-1:0] env_r, env_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;

  logic              accept;
  logic              tick, click_start;
  logic              click_pol, alarm_pol;
  logic              div_start;
  div_status_t       div_status;
  logic [DIVIDEND_W-1:0] div_quot;
  logic [DIVIDEND_W-1:0] product;

  logic signed [MIX_W-1:0] click_term, alarm_term, mix_sum;
  logic signed [SAMPLE_W-1:0] mix_sat;

  assign in_chan.ready = (state_r == ST_IDLE) && !div_status.busy;
  assign accept        = in_chan.valid && in_chan.ready;
  assign tick          = accept && (in_chan.func == FUNC_TICK);
  assign click_start   = accept && (in_chan.func == FUNC_CLICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      click_length_r <= RST_CLICK_LENGTH;
      click_half_r   <= RST_CLICK_HALF_PERIOD;
      alarm_half_r   <= RST_ALARM_HALF_PERIOD;
      click_amp_r    <= RST_CLICK_AMPLITUDE;
      alarm_amp_r    <= RST_ALARM_AMPLITUDE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLICK_LENGTH:      click_length_r <= cfg_wdata[LEN_W-1:0];
        CFG_CLICK_HALF_PERIOD: click_half_r   <= cfg_wdata[HALF_W-1:0];
        CFG_ALARM_HALF_PERIOD: alarm_half_r   <= cfg_wdata[HALF_W-1:0];
        CFG_CLICK_AMPLITUDE:   click_amp_r    <= cfg_wdata[AMP_W-1:0];
        CFG_ALARM_AMPLITUDE:   alarm_amp_r    <= cfg_wdata[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  cas_phase u_click_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (tick && (click_left_r != '0)),
    .clear       (click_start),
    .half_period (click_half_r),
    .polarity    (click_pol)
  );

  cas_phase u_alarm_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (tick && alarm_en_r),
    .clear       (tick && !alarm_en_r),
    .half_period (alarm_half_r),
    .polarity    (alarm_pol)
  );

  assign product = {{LEN_W{1'b0}}, click_amp_r} * {{AMP_W{1'b0}}, left_snap_r};

  cas_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (click_length_r),
    .status   (div_status),
    .quotient (div_quot)
  );

  // mix and saturate
  assign click_term = cpol_snap_r ? $signed({2'b00, env_r}) : -$signed({2'b00, env_r});
  assign alarm_term = !alarm_snap_r ? '0 :
                      apol_snap_r ? $signed(MIX_W'(alarm_amp_r))
                                  : -$signed(MIX_W'(alarm_amp_r));
  assign mix_sum    = click_term + alarm_term;

  always_comb begin
    if (mix_sum > $signed(MIX_W'(32767)))
      mix_sat = 16'sh7fff;
    else if (mix_sum < -$signed(MIX_W'(32768)))
      mix_sat = 16'sh8000;
    else
      mix_sat = mix_sum[SAMPLE_W-1:0];
  end

  always_comb begin
    state_nxt      = state_r;
    alarm_en_nxt   = alarm_en_r;
    click_left_nxt = click_left_r;
    left_snap_nxt  = left_snap_r;
    cpol_snap_nxt  = cpol_snap_r;
    apol_snap_nxt  = apol_snap_r;
    alarm_snap_nxt = alarm_snap_r;
    env_nxt        = env_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_sample_nxt = out_sample_r;
    div_start      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_chan.func)
            FUNC_CLICK: click_left_nxt = click_length_r;
            FUNC_ALARM: alarm_en_nxt = in_chan.alarm_level;
            FUNC_TICK: begin
              left_snap_nxt  = click_left_r;
              cpol_snap_nxt  = click_pol;
              apol_snap_nxt  = alarm_pol;
              alarm_snap_nxt = alarm_en_r;
              if (click_left_r != '0) begin
                click_left_nxt = click_left_r - 1'b1;
                if (click_length_r == '0) begin
                  // zero length: envelope stays at full amplitude
                  env_nxt   = DIVIDEND_W'(click_amp_r);
                  state_nxt = ST_MIX;
                end else begin
                  state_nxt = ST_MULT;
                end
              end else begin
                env_nxt   = '0;
                state_nxt = ST_MIX;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MULT: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_status.done) begin
          env_nxt   = div_quot;
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = mix_sat;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      alarm_en_r   <= 1'b0;
      click_left_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      alarm_en_r   <= alarm_en_nxt;
      click_left_r <= click_left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_snap_r  <= left_snap_nxt;
    cpol_snap_r  <= cpol_snap_nxt;
    apol_snap_r  <= apol_snap_nxt;
    alarm_snap_r <= alarm_snap_nxt;
    env_r        <= env_nxt;
    out_sample_r <= out_sample_nxt;
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.sample = out_sample_r;

endmodule
